// File: design/wbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbd_pkg
// types, microprogram and calendar helpers for the weekday stepping core
// ---------------------------------------------------------------------------
package wbd_pkg;

  localparam logic [13:0] YearMax   = 14'd9999;
  localparam logic [12:0] Recip100  = 13'd5243;  // ceil(2^19 / 100)
  localparam int          RecipBits = 19;

  // register indexes of the configuration port
  localparam logic [2:0] REG_REF_DAY     = 3'd0;
  localparam logic [2:0] REG_REF_MONTH   = 3'd1;
  localparam logic [2:0] REG_REF_YEAR    = 3'd2;
  localparam logic [2:0] REG_REF_WEEKDAY = 3'd3;

  typedef logic [2:0] pc_t;

  // microprogram addresses
  localparam pc_t PC_WAIT     = 3'd0;
  localparam pc_t PC_LEAP_T   = 3'd1;
  localparam pc_t PC_LEAP_R   = 3'd2;
  localparam pc_t PC_CHECK    = 3'd3;
  localparam pc_t PC_LOAD     = 3'd4;
  localparam pc_t PC_STEP     = 3'd5;
  localparam pc_t PC_EMIT_OK  = 3'd6;
  localparam pc_t PC_EMIT_ERR = 3'd7;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_CHECK_T,
    ACT_LOAD,
    ACT_STEP,
    ACT_EMIT_OK,
    ACT_EMIT_ERR
  } act_t;

  typedef enum logic [1:0] {
    LSRC_TARGET,
    LSRC_REF,
    LSRC_CUR
  } lsrc_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_ACC,
    COND_BAD,
    COND_EQUAL,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    act_t  act;
    lsrc_t lsrc;
    cond_t cond;
    pc_t   jump;   // taken when cond holds
    pc_t   next;   // taken otherwise
  } ucw_t;

  typedef struct packed {
    logic in_acc;
    logic bad;
    logic equal;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
  } ref_cfg_t;

  localparam int UcodeDepth = 8;

  localparam ucw_t UCODE [UcodeDepth] = '{
    '{ACT_ACCEPT,   LSRC_TARGET, COND_IN_ACC,   PC_LEAP_T,   PC_WAIT},
    '{ACT_NONE,     LSRC_TARGET, COND_ALWAYS,   PC_LEAP_R,   PC_LEAP_R},
    '{ACT_CHECK_T,  LSRC_REF,    COND_ALWAYS,   PC_CHECK,    PC_CHECK},
    '{ACT_NONE,     LSRC_REF,    COND_BAD,      PC_EMIT_ERR, PC_LOAD},
    '{ACT_LOAD,     LSRC_REF,    COND_ALWAYS,   PC_STEP,     PC_STEP},
    '{ACT_STEP,     LSRC_CUR,    COND_EQUAL,    PC_EMIT_OK,  PC_STEP},
    '{ACT_EMIT_OK,  LSRC_CUR,    COND_OUT_FREE, PC_WAIT,     PC_EMIT_OK},
    '{ACT_EMIT_ERR, LSRC_REF,    COND_OUT_FREE, PC_WAIT,     PC_EMIT_ERR}
  };

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(logic [4:0] d, logic [3:0] m, logic [13:0] y,
                                   logic leap);
    logic ok;
    ok = (y != 14'd0) && (y <= YearMax) && (m != 4'd0) && (m <= 4'd12) &&
         (d != 5'd0) && (d <= month_len(m, leap));
    return ok;
  endfunction

endpackage

// File: design/wbd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbd_if
// request channels of the weekday stepping core: target, result, config
// ---------------------------------------------------------------------------
interface wbd_target_if;
  logic        valid;
  logic        ready;
  logic [4:0]  target_day;
  logic [3:0]  target_month;
  logic [13:0] target_year;

  modport source (output valid, target_day, target_month, target_year, input ready);
  modport sink   (input valid, target_day, target_month, target_year, output ready);
endinterface

interface wbd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] weekday;
  logic       date_error;

  modport source (output valid, weekday, date_error, input ready);
  modport sink   (input valid, weekday, date_error, output ready);
endinterface

interface wbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/wbd_leap_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbd_leap_unit
// registered gregorian leap-year test, divide by 100 through a reciprocal
// ---------------------------------------------------------------------------
module wbd_leap_unit (
  input  logic        clk,
  input  logic [13:0] year,
  output logic        leap
);
  import wbd_pkg::*;

  logic [26:0] prod;
  logic [7:0]  quot;
  logic [14:0] back;
  logic        div100;
  logic        leap_next;

  // quotient is exact for every 14-bit year
  assign prod   = 27'(year) * 27'(Recip100);
  assign quot   = prod[26:RecipBits];
  assign back   = {1'b0, quot, 6'b0} + {2'b0, quot, 5'b0} + {5'b0, quot, 2'b0};
  assign div100 = (back == {1'b0, year});

  assign leap_next = (year[1:0] == 2'd0) && (!div100 || (quot[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    leap <= leap_next;
  end

endmodule

// File: design/wbd_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbd_sequencer
// step counter and microprogram fetch with conditional jumps
// ---------------------------------------------------------------------------
module wbd_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  wbd_pkg::status_t status,
  output wbd_pkg::ucw_t    cw,
  output wbd_pkg::pc_t     pc
);
  import wbd_pkg::*;

  pc_t  pc_next;
  logic taken;

  // next step
  always_comb begin
    case (cw.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_IN_ACC:   taken = status.in_acc;
      COND_BAD:      taken = status.bad;
      COND_EQUAL:    taken = status.equal;
      COND_OUT_FREE: taken = status.out_free;
      default:       taken = 1'b1;
    endcase
    pc_next = taken ? cw.jump : cw.next;
  end

  // control word of the current step
  always_comb begin
    cw = UCODE[pc];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/wbd_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wbd_datapath
// target latch, date checks, one-day walker and result register
// ---------------------------------------------------------------------------
module wbd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  wbd_pkg::ucw_t     cw,
  input  wbd_pkg::ref_cfg_t ref_cfg,
  input  logic              in_valid,
  input  logic [4:0]        in_day,
  input  logic [3:0]        in_month,
  input  logic [13:0]       in_year,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [2:0]        out_weekday,
  output logic              out_error,
  output wbd_pkg::status_t  status
);
  import wbd_pkg::*;

  logic [4:0]  tgt_day;
  logic [3:0]  tgt_month;
  logic [13:0] tgt_year;
  logic        tgt_ok;

  logic [4:0]  cur_day, cur_day_next;
  logic [3:0]  cur_month, cur_month_next;
  logic [13:0] cur_year, cur_year_next;
  logic [2:0]  cur_weekday, cur_weekday_next;

  logic [13:0] leap_year;
  logic        leap;
  logic [2:0]  base_weekday;
  logic        forward;
  logic [4:0]  cur_len;
  logic        emit;

  wbd_leap_unit u_leap (
    .clk  (clk),
    .year (leap_year),
    .leap (leap)
  );

  always_comb begin
    case (cw.lsrc)
      LSRC_TARGET: leap_year = tgt_year;
      LSRC_REF:    leap_year = ref_cfg.year;
      LSRC_CUR:    leap_year = cur_year;
      default:     leap_year = cur_year;
    endcase
  end

  assign in_ready        = (cw.act == ACT_ACCEPT);
  assign status.in_acc   = in_ready && in_valid;
  assign status.bad      = !tgt_ok ||
                           !date_ok(ref_cfg.day, ref_cfg.month, ref_cfg.year, leap);
  assign status.equal    = ({cur_year, cur_month, cur_day} ==
                            {tgt_year, tgt_month, tgt_day});
  assign status.out_free = !out_valid || out_ready;

  assign forward      = ({cur_year, cur_month, cur_day} <
                         {tgt_year, tgt_month, tgt_day});
  assign base_weekday = (ref_cfg.weekday == 3'd0) ? 3'd7 : ref_cfg.weekday;
  // the registered leap lags a year change, but the lag never reaches a february
  assign cur_len      = month_len(cur_month, leap);
  assign emit         = status.out_free &&
                        ((cw.act == ACT_EMIT_OK) || (cw.act == ACT_EMIT_ERR));

  // one day forward or back
  always_comb begin
    cur_day_next     = cur_day;
    cur_month_next   = cur_month;
    cur_year_next    = cur_year;
    cur_weekday_next = cur_weekday;
    if (forward) begin
      cur_weekday_next = (cur_weekday == 3'd7) ? 3'd1 : cur_weekday + 3'd1;
      if (cur_day < cur_len) begin
        cur_day_next = cur_day + 5'd1;
      end else begin
        cur_day_next = 5'd1;
        if (cur_month < 4'd12) begin
          cur_month_next = cur_month + 4'd1;
        end else begin
          cur_month_next = 4'd1;
          cur_year_next  = cur_year + 14'd1;
        end
      end
    end else begin
      cur_weekday_next = (cur_weekday == 3'd1) ? 3'd7 : cur_weekday - 3'd1;
      if (cur_day > 5'd1) begin
        cur_day_next = cur_day - 5'd1;
      end else if (cur_month > 4'd1) begin
        cur_month_next = cur_month - 4'd1;
        cur_day_next   = month_len(cur_month - 4'd1, leap);
      end else begin
        cur_month_next = 4'd12;
        cur_day_next   = 5'd31;
        cur_year_next  = cur_year - 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status.in_acc) begin
      tgt_day   <= in_day;
      tgt_month <= in_month;
      tgt_year  <= in_year;
    end
    if (cw.act == ACT_CHECK_T) begin
      tgt_ok <= date_ok(tgt_day, tgt_month, tgt_year, leap);
    end
    if (emit) begin
      out_weekday <= (cw.act == ACT_EMIT_OK) ? cur_weekday : 3'd1;
      out_error   <= (cw.act == ACT_EMIT_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day     <= 5'd1;
      cur_month   <= 4'd1;
      cur_year    <= 14'd1;
      cur_weekday <= 3'd1;
    end else if (cw.act == ACT_LOAD) begin
      cur_day     <= ref_cfg.day;
      cur_month   <= ref_cfg.month;
      cur_year    <= ref_cfg.year;
      cur_weekday <= base_weekday;
    end else if ((cw.act == ACT_STEP) && !status.equal) begin
      cur_day     <= cur_day_next;
      cur_month   <= cur_month_next;
      cur_year    <= cur_year_next;
      cur_weekday <= cur_weekday_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/weekday_by_day_stepping_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weekday_by_day_stepping_core
// weekday of a date, found by walking day by day from a reference date
// ---------------------------------------------------------------------------
// Each target request returns one result: its weekday (1 Monday .. 7 Sunday)
// and a date_error flag. After acceptance a request runs through the leap
// tests, the date checks, the walker load and the walk before its result is
// in the output register; the walker moves one day per cycle over the D days
// between the reference date and the target, and D reaches about 3.65 million
// over the full 1..9999 year range. A target or reference date that does not
// exist gives weekday 1 with date_error set, with no walk. The next request is
// taken as soon as the previous result sits in the output register, even while
// it still waits to be taken. The user must write the reference date and weekday
// through the config port only while no request is in flight; the core itself
// does not enforce this. A reference weekday of 0 counts as Sunday.
module weekday_by_day_stepping_core (
  input logic                clk,
  input logic                rst,
  wbd_target_if.sink         target,
  wbd_result_if.source       result,
  wbd_cfg_if.sink            cfg
);
  import wbd_pkg::*;

  ref_cfg_t ref_cfg;
  ucw_t     cw;
  pc_t      pc;
  status_t  status;

  // config registers, always ready; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cfg.day     <= 5'd1;
      ref_cfg.month   <= 4'd1;
      ref_cfg.year    <= 14'd2001;
      ref_cfg.weekday <= 3'd1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_REF_DAY:     ref_cfg.day     <= cfg.data[4:0];
        REG_REF_MONTH:   ref_cfg.month   <= cfg.data[3:0];
        REG_REF_YEAR:    ref_cfg.year    <= cfg.data;
        REG_REF_WEEKDAY: ref_cfg.weekday <= cfg.data[2:0];
        default: begin
        end
      endcase
    end
  end

  // microprogram: wait, leap of target, check target, check reference,
  // load walker, step until equal, emit
  wbd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw),
    .pc     (pc)
  );

  wbd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .ref_cfg     (ref_cfg),
    .in_valid    (target.valid),
    .in_day      (target.target_day),
    .in_month    (target.target_month),
    .in_year     (target.target_year),
    .in_ready    (target.ready),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .out_weekday (result.weekday),
    .out_error   (result.date_error),
    .status      (status)
  );

`ifndef SYNTHESIS
  // requests are only taken at the wait step
  a_ready_at_wait: assert property (@(posedge clk) disable iff (rst)
    target.ready |-> (pc == PC_WAIT))
    else $error("target ready outside the wait step");

  // an accepted request starts the leap test of the target
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (target.valid && target.ready) |=> (pc == PC_LEAP_T))
    else $error("accepted request did not start the program");

  // a new result only appears from an emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(pc) == PC_EMIT_OK || $past(pc) == PC_EMIT_ERR))
    else $error("result raised outside an emit step");

  // flagged results carry weekday 1
  a_error_weekday: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.date_error) |-> (result.weekday == 3'd1))
    else $error("flagged result with weekday other than 1");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for the weekday stepping core. A scoreboard class predicts the
// weekday and the date_error flag of every target request that the core
// accepts, keeping its own copy of the reference date, and compares each
// returned result with the oldest prediction. Targets are kept within a few
// hundred days of the reference so the day-by-day walk stays short, mixed
// with nonexistent dates, under several reference settings.
// ---------------------------------------------------------------------------
module tb;
  import wbd_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int LongHold     = 400;
  localparam int SettleCycles = 16;
  localparam int YearTop      = 9999;

  // indexes past the last register, writes there must be ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd4;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] weekday;
    logic       date_error;
  } day_result_t;

  typedef enum int {
    ALWAYS_READY,
    COIN_FLIP,
    MOSTLY_STALLED,
    MOSTLY_READY
  } stall_mode_t;

  typedef enum int {
    FLAW_DAY_ZERO,
    FLAW_DAY_PAST_END,
    FLAW_MONTH_ZERO,
    FLAW_MONTH_HIGH,
    FLAW_YEAR_ZERO,
    FLAW_YEAR_HIGH
  } date_flaw_t;

  // -------------------------------------------------------------------------
  // scoreboard: calendar predictor plus the queue of outstanding weekdays
  // -------------------------------------------------------------------------
  class weekday_scoreboard;
    bit [4:0]    ref_day;
    bit [3:0]    ref_month;
    bit [13:0]   ref_year;
    bit [2:0]    ref_weekday;
    bit [4:0]    cur_day;
    bit [3:0]    cur_month;
    bit [13:0]   cur_year;
    bit [2:0]    cur_weekday;
    day_result_t expected_days[$];
    int          errors;
    int          requests;
    int          flagged;
    int          longest_walk;

    function new();
      ref_day = 1;
      ref_month = 1;
      ref_year = 2001;
      ref_weekday = 1;
      cur_day = 1;
      cur_month = 1;
      cur_year = 1;
      cur_weekday = 1;
      errors = 0;
      requests = 0;
      flagged = 0;
      longest_walk = 0;
    endfunction

    function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int month_days(int m, int y);
      if (m == 2) return leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function bit date_exists(int d, int m, int y);
      if (y < 1 || y > YearTop || m < 1 || m > 12 || d < 1) return 0;
      return d <= month_days(m, y);
    endfunction

    // days elapsed since 1 january of year 1
    function int day_index(int d, int m, int y);
      int p;
      int n;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (int k = 1; k < m; k++) n += month_days(k, y);
      return n + d - 1;
    endfunction

    function void write_reg(logic [2:0] index, logic [13:0] data);
      case (index)
        REG_REF_DAY:     ref_day = data[4:0];
        REG_REF_MONTH:   ref_month = data[3:0];
        REG_REF_YEAR:    ref_year = data;
        REG_REF_WEEKDAY: ref_weekday = data[2:0];
        default: ;
      endcase
    endfunction

    function void note_target(logic [4:0] d, logic [3:0] m, logic [13:0] y);
      day_result_t r;
      int          nr;
      int          nt;
      int          walk_days;
      int          shift;
      int          base;
      requests++;
      if (!date_exists(d, m, y) || !date_exists(ref_day, ref_month, ref_year)) begin
        r.weekday = 3'd1;
        r.date_error = 1'b1;
      end else begin
        nr = day_index(ref_day, ref_month, ref_year);
        nt = day_index(d, m, y);
        walk_days = (nt > nr) ? nt - nr : nr - nt;
        if (walk_days > longest_walk) longest_walk = walk_days;
        shift = ((nt - nr) % 7 + 7) % 7;
        // weekday zero behaves as sunday
        base = (ref_weekday == 0) ? 7 : ref_weekday;
        r.weekday = 3'((base - 1 + shift) % 7 + 1);
        r.date_error = 1'b0;
        cur_day = d;
        cur_month = m;
        cur_year = y;
        cur_weekday = r.weekday;
      end
      expected_days.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_result(logic [2:0] weekday, logic date_error);
      day_result_t want;
      if (date_error === 1'b1) flagged++;
      if (expected_days.size() == 0) begin
        report($sformatf("result with nothing outstanding: weekday %0d date_error %0b",
                         weekday, date_error));
        return;
      end
      want = expected_days.pop_front();
      if (weekday !== want.weekday)
        report($sformatf("weekday got %0d want %0d", weekday, want.weekday));
      if (date_error !== want.date_error)
        report($sformatf("date_error got %0b want %0b", date_error, want.date_error));
    endtask

    function int pending();
      return expected_days.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // clock, reset, channels and the core
  // -------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  int unsigned       cycle_count = 0;
  bit                hold_request = 0;
  int                phases = 1;       // the reset setting counts as the first
  int                burst_left = 0;
  int                gap_max = 4;
  weekday_scoreboard sb = new();

  wbd_target_if target_ch();
  wbd_result_if result_ch();
  wbd_cfg_if    cfg_ch();

  weekday_by_day_stepping_core uut (
    .clk    (clk),
    .rst    (rst),
    .target (target_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // every accepted result goes straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.weekday, result_ch.date_error);
  end

  // runaway guard, far above the slowest run this bench makes
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

  // -------------------------------------------------------------------------
  // result side: stall pattern in stretches of random mode, plus one long
  // hold-off when the stimulus asks for it so the core backs up
  // -------------------------------------------------------------------------
  initial begin : receiver
    int          hold_left;
    int          span;
    stall_mode_t mode;
    hold_left = 0;
    span = 0;
    mode = ALWAYS_READY;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = LongHold - 1;
        result_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          span = $urandom_range(8, 64);
        end
        span--;
        case (mode)
          ALWAYS_READY:   result_ch.ready <= 1'b1;
          COIN_FLIP:      result_ch.ready <= 1'($urandom_range(0, 1));
          MOSTLY_STALLED: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default:        result_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // drivers: all entered and left at a falling edge
  // -------------------------------------------------------------------------

  // lower valid and idle the sender, nothing for n of zero
  task automatic pause_sender(int n);
    if (n > 0) begin
      target_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // one target request, valid is left high for a back-to-back follower
  task automatic send_target(int d, int m, int y);
    if (burst_left == 0) begin
      pause_sender($urandom_range(0, gap_max));
      burst_left = $urandom_range(1, 10);
    end
    target_ch.valid <= 1'b1;
    target_ch.target_day <= 5'(d);
    target_ch.target_month <= 4'(m);
    target_ch.target_year <= 14'(y);
    do @(posedge clk); while (!target_ch.ready);
    sb.note_target(target_ch.target_day, target_ch.target_month, target_ch.target_year);
    burst_left--;
    @(negedge clk);
  endtask

  // sender waits until every outstanding weekday has come back
  task automatic drain();
    target_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(logic [2:0] index, logic [13:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(cfg_ch.index, cfg_ch.data);
    @(negedge clk);
  endtask

  // new reference date; junk rides in the unused upper data bits, and one
  // write to a spare index must leave everything as it was
  task automatic set_reference(int d, int m, int y, int w);
    phases++;
    cfg_write(REG_REF_YEAR, 14'(y));
    cfg_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 14'($urandom));
    cfg_write(REG_REF_MONTH, {10'($urandom), 4'(m)});
    cfg_write(REG_REF_DAY, {9'($urandom), 5'(d)});
    cfg_write(REG_REF_WEEKDAY, {11'($urandom), 3'(w)});
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // walk a valid date by delta days, pinned at the ends of the year range
  task automatic step_date(inout int d, inout int m, inout int y, input int delta);
    for (int k = 0; k < delta; k++) begin
      if (d < sb.month_days(m, y)) d++;
      else if (m < 12) begin
        m++;
        d = 1;
      end else if (y < YearTop) begin
        y++;
        m = 1;
        d = 1;
      end
    end
    for (int k = 0; k < -delta; k++) begin
      if (d > 1) d--;
      else if (m > 1) begin
        m--;
        d = sb.month_days(m, y);
      end else if (y > 1) begin
        y--;
        m = 12;
        d = 31;
      end
    end
  endtask

  // turn a date into one that does not exist
  task automatic corrupt_date(inout int d, inout int m, inout int y);
    date_flaw_t flaw;
    flaw = date_flaw_t'($urandom_range(0, 5));
    case (flaw)
      FLAW_DAY_ZERO: d = 0;
      FLAW_DAY_PAST_END: begin
        if (sb.month_days(m, y) < 31) d = $urandom_range(sb.month_days(m, y) + 1, 31);
        else m = 0;
      end
      FLAW_MONTH_ZERO: m = 0;
      FLAW_MONTH_HIGH: m = $urandom_range(13, 15);
      FLAW_YEAR_ZERO:  y = 0;
      default:         y = $urandom_range(YearTop + 1, 16383);
    endcase
  endtask

  // one random reference setting and a burst of targets around it
  task automatic random_phase(bit raise_hold);
    int  d;
    int  m;
    int  y;
    int  td;
    int  tm;
    int  ty;
    int  n;
    int  pick;
    int  offset;
    bit  ref_good;
    pick = $urandom_range(0, 9);
    y = (pick == 0) ? 1 : (pick == 1) ? YearTop : $urandom_range(1, YearTop);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.month_days(m, y));
    ref_good = ($urandom_range(0, 5) != 0);
    if (!ref_good) corrupt_date(d, m, y);
    set_reference(d, m, y, $urandom_range(0, 7));
    pick = $urandom_range(0, 2);
    gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 12;
    n = $urandom_range(11, 15);
    for (int i = 0; i < n; i++) begin
      // long receiver stall while the sender keeps offering requests
      if (raise_hold && i == 4) hold_request = 1;
      if (!ref_good) begin
        // bad reference: every target is flagged, no walk, any fields
        send_target($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
      end else begin
        td = d;
        tm = m;
        ty = y;
        pick = $urandom_range(0, 19);
        if (pick < 10) offset = $urandom_range(0, 7);
        else if (pick < 17) offset = $urandom_range(8, 60);
        else offset = $urandom_range(61, 400);
        step_date(td, tm, ty, $urandom_range(0, 1) ? offset : -offset);
        if ($urandom_range(0, 4) == 0) td = sb.month_days(tm, ty);
        if ($urandom_range(0, 4) == 0) corrupt_date(td, tm, ty);
        send_target(td, tm, ty);
      end
    end
    drain();
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    target_ch.valid = 1'b0;
    target_ch.target_day = '0;
    target_ch.target_month = '0;
    target_ch.target_year = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset reference, monday 1 jan 2001: both walk directions, a leap day,
    // month ends, then every flavor of nonexistent target
    send_target(1, 1, 2001);
    send_target(31, 12, 2000);
    send_target(29, 2, 2000);
    send_target(31, 1, 2001);
    send_target(31, 12, 2001);
    send_target(29, 2, 2001);
    send_target(0, 5, 2001);
    send_target(31, 4, 2001);
    send_target(1, 0, 2001);
    send_target(1, 13, 2001);
    send_target(15, 15, 2001);
    send_target(1, 1, 0);
    send_target(1, 1, 10000);
    send_target(31, 15, 16383);
    drain();

    // top of the year range
    set_reference(31, 12, YearTop, 7);
    send_target(31, 12, YearTop);
    send_target(1, 1, YearTop);
    drain();

    // bottom of the year range, weekday zero taken as sunday
    set_reference(1, 1, 1, 0);
    send_target(1, 1, 1);
    send_target(1, 3, 1);
    send_target(31, 12, 1);
    drain();

    // reference that does not exist: 1900 is not a leap year
    set_reference(29, 2, 1900, 3);
    send_target(28, 2, 1900);
    send_target(1, 3, 1900);
    drain();

    for (int p = 0; p < 6; p++) random_phase(p == 1);

    $display("covered %0d target requests under %0d reference settings, %0d flagged",
             sb.requests, phases, sb.flagged);
    $display("longest walk %0d days, receiver hold of %0d cycles, %0d mismatches",
             sb.longest_walk, LongHold, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
